/* hw/rtl/pcm_sample_unpacker_macros.svh */
// Assertion macros shared by the PCM sample unpacker RTL.
`ifndef PCM_SAMPLE_UNPACKER_MACROS_SVH
`define PCM_SAMPLE_UNPACKER_MACROS_SVH
`ifndef SYNTHESIS
`define PCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCM_ASSERT_IMP(lbl, ante, cons, msg)
`define PCM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/pcm_unp_pkg.sv */
// Types and constants of the PCM sample unpacker.
package pcm_unp_pkg;

  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 32;
  localparam int PART_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LITTLE_ENDIAN = 2'd2;

  localparam logic [2:0] RST_SAMPLE_BYTES  = 3'd2;
  localparam logic [1:0] RST_CHANNEL_COUNT = 2'd2;
  localparam logic       RST_LITTLE_ENDIAN = 1'b1;

  localparam logic [BYTE_W-1:0] FLIP_TOP = 8'h80;

  typedef struct packed {
    logic [2:0] sample_bytes;
    logic [1:0] channel_count;
    logic       little_endian;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
  } res_t;

endpackage

/* hw/rtl/pcm_unp_cfg.sv */
// Configuration registers of the PCM sample unpacker.
module pcm_unp_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcm_unp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcm_unp_pkg::CFG_DATA_W-1:0] cfg_data,
  output pcm_unp_pkg::cfg_t                 cfg
);
  import pcm_unp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLE_BYTES:  cfg_nxt.sample_bytes  = cfg_data;
        REG_CHANNEL_COUNT: cfg_nxt.channel_count = cfg_data[1:0];
        REG_LITTLE_ENDIAN: cfg_nxt.little_endian = cfg_data[0];
        default:           cfg_nxt = cfg_r; // unmapped index: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_bytes  <= RST_SAMPLE_BYTES;
      cfg_r.channel_count <= RST_CHANNEL_COUNT;
      cfg_r.little_endian <= RST_LITTLE_ENDIAN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hw/rtl/pcm_unp_asm.sv */
// Sample assembly: byte gathering, justification and channel pairing.
module pcm_unp_asm (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcm_unp_pkg::cfg_t             cfg,
  input  logic                          take,
  input  logic [pcm_unp_pkg::BYTE_W-1:0] byte_in,
  input  logic                          sos,
  output pcm_unp_pkg::res_t             res
);
  import pcm_unp_pkg::*;

  `include "pcm_sample_unpacker_macros.svh"

  logic [PART_W-1:0]   partial_r, partial_nxt;
  logic [1:0]          bpos_r, bpos_nxt;
  logic [SAMPLE_W-1:0] held_r, held_nxt;
  logic                chpos_r, chpos_nxt;

  logic [1:0]          nm1;
  logic                mono;
  logic [1:0]          bpos_eff;
  logic                chpos_eff;
  logic                completes;
  logic [PART_W-1:0]   part_grow;
  logic [SAMPLE_W-1:0] v_raw;
  logic [SAMPLE_W-1:0] v_mask;
  logic [SAMPLE_W-1:0] word;

  always_comb begin
    unique case (cfg.sample_bytes) inside
      3'd0, 3'd1: nm1 = 2'd0;
      3'd2:       nm1 = 2'd1;
      3'd3:       nm1 = 2'd2;
      default:    nm1 = 2'd3;
    endcase
  end

  assign mono      = (cfg.channel_count <= 2'd1);
  assign bpos_eff  = sos ? 2'd0 : bpos_r;
  assign chpos_eff = sos ? 1'b0 : chpos_r;
  assign completes = (bpos_eff >= nm1);

  always_comb begin
    if (bpos_eff == 2'd0) begin
      part_grow = {16'd0, byte_in};
    end else if (cfg.little_endian) begin
      part_grow = partial_r | ({16'd0, byte_in} << {bpos_eff, 3'b000});
    end else begin
      part_grow = {partial_r[15:0], byte_in};
    end
  end

  always_comb begin
    if (bpos_eff == 2'd0) begin
      v_raw = {24'd0, byte_in};
    end else if (cfg.little_endian) begin
      v_raw = {8'd0, partial_r} | ({24'd0, byte_in} << {nm1, 3'b000});
    end else begin
      v_raw = {partial_r, byte_in};
    end
    case (nm1)
      2'd0:    v_mask = 32'h0000_00FF;
      2'd1:    v_mask = 32'h0000_FFFF;
      2'd2:    v_mask = 32'h00FF_FFFF;
      default: v_mask = 32'hFFFF_FFFF;
    endcase
    word = (v_raw & v_mask) << {2'd3 - nm1, 3'b000};
    // unsigned 8-bit little-endian input: flip to signed
    if (nm1 == 2'd0 && cfg.little_endian) begin
      word = word ^ {FLIP_TOP, 24'd0};
    end
  end

  assign res.valid = completes && (mono || chpos_eff);
  assign res.left  = mono ? word : held_r;
  assign res.right = word;

  always_comb begin
    partial_nxt = partial_r;
    bpos_nxt    = bpos_r;
    held_nxt    = held_r;
    chpos_nxt   = chpos_r;
    if (take) begin
      if (!completes) begin
        partial_nxt = part_grow;
        bpos_nxt    = bpos_eff + 2'd1;
        chpos_nxt   = chpos_eff;
      end else begin
        partial_nxt = '0;
        bpos_nxt    = 2'd0;
        if (mono) begin
          chpos_nxt = 1'b0;
        end else begin
          chpos_nxt = !chpos_eff;
          if (!chpos_eff) begin
            held_nxt = word;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      bpos_r    <= 2'd0;
      held_r    <= '0;
      chpos_r   <= 1'b0;
    end else begin
      partial_r <= partial_nxt;
      bpos_r    <= bpos_nxt;
      held_r    <= held_nxt;
      chpos_r   <= chpos_nxt;
    end
  end

  `PCM_ASSERT_IMP(a_mono_dup, res.valid && mono, res.left == res.right, "mono channels differ")
  `PCM_ASSERT_NEXT(a_done_clears, take && completes, bpos_r == 2'd0, "byte count not cleared")
  `PCM_ASSERT_NEXT(a_left_held, take && completes && !mono && !chpos_eff, chpos_r && held_r == $past(word), "left sample not held")

endmodule

/* hw/rtl/pcm_sample_unpacker.sv */
// Top level of the PCM sample unpacker: input stage, assembly and result register.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, in_byte, in_start_of_stream  | sink
//   out     | out_valid/out_ready, out_left_sample, out_right_sample | source
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | sink
//
// One byte per cycle while completed frames can go to the result register: a byte is
// held in the input register, assembled there, and its frame, if it completes one,
// lands in the result register when the byte is taken.
// A held result stalls only bytes that complete a frame; other bytes keep flowing.
// Reset (synchronous, rst_n low) clears the assembly state and loads the register defaults.
module pcm_sample_unpacker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pcm_unp_pkg::BYTE_W-1:0]     in_byte,
  input  logic                               in_start_of_stream,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pcm_unp_pkg::SAMPLE_W-1:0]   out_left_sample,
  output logic [pcm_unp_pkg::SAMPLE_W-1:0]   out_right_sample,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pcm_unp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcm_unp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcm_unp_pkg::*;

  `include "pcm_sample_unpacker_macros.svh"

  cfg_t cfg;
  res_t res;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_sos_r;
  logic              out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_left_r, out_right_r;
  logic              out_free;
  logic              take;
  logic              in_acc;

  pcm_unp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcm_unp_asm u_asm (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .take    (take),
    .byte_in (s1_byte_r),
    .sos     (s1_sos_r),
    .res     (res)
  );

  assign out_free = !out_valid_r || out_ready;
  // advance the held byte unless its frame has nowhere to go
  assign take     = s1_valid_r && (!res.valid || out_free);
  assign in_ready = !s1_valid_r || take;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (take && res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_byte;
      s1_sos_r  <= in_start_of_stream;
    end
    if (take && res.valid) begin
      out_left_r  <= res.left;
      out_right_r <= res.right;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_left_r;
  assign out_right_sample = out_right_r;

  `PCM_ASSERT_NEXT(a_frame_lands, take && res.valid, out_valid, "frame not registered")
  `PCM_ASSERT_IMP(a_no_overrun, out_valid_r && !out_ready && res.valid, !take, "result overrun")
  `PCM_ASSERT_IMP(a_stall_source, !in_ready, s1_valid_r && res.valid && !out_free, "spurious input stall")

endmodule

/* verif/tb_pcm_sample_unpacker.sv */
// Self-checking testbench for the PCM sample unpacker: stimulus, frame predictor and checker.
module tb_pcm_sample_unpacker;
  timeunit 1ns;
  timeprecision 1ps;

  import pcm_unp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;  // unmapped index, write is dropped

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_byte;
  logic                  in_start_of_stream;
  logic                  out_valid;
  logic                  out_ready;
  logic [SAMPLE_W-1:0]   out_left_sample;
  logic [SAMPLE_W-1:0]   out_right_sample;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcm_sample_unpacker u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .in_start_of_stream (in_start_of_stream),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_left_sample    (out_left_sample),
    .out_right_sample   (out_right_sample),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Predictor copy of the format registers and the assembly state
  cfg_t              fmt_cfg;
  logic [PART_W-1:0] asm_part;
  logic [1:0]        asm_pos;
  logic [31:0]       asm_held;
  logic              asm_right;
  res_t              frames_q[$];

  bit          tx_idle_en;
  bit          rx_idle_en;
  int          rx_hold_cycles;
  int unsigned err_count;
  int unsigned bytes_sent;
  int unsigned frames_checked;
  int unsigned formats_used;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned sample_len();
    if (fmt_cfg.sample_bytes == 3'd0) return 1;
    if (fmt_cfg.sample_bytes > 3'd4) return 4;
    return fmt_cfg.sample_bytes;
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] corner[4];
    corner = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    if ($urandom_range(7, 0) == 0) return corner[$urandom_range(3, 0)];
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Advance the assembly by one byte; queue a frame when one completes
  task automatic assemble_byte(input logic [7:0] b, input logic sos);
    int unsigned n;
    logic [31:0] v;
    logic [31:0] mask;
    logic [31:0] word;
    res_t        fr;
    n = sample_len();
    if (sos) begin
      asm_pos   = 2'd0;
      asm_right = 1'b0;
    end
    if (asm_pos + 1 < n) begin
      if (asm_pos == 2'd0) asm_part = {16'h0, b};
      else if (fmt_cfg.little_endian) asm_part = asm_part | (24'(b) << (8 * asm_pos));
      else asm_part = {asm_part[15:0], b};
      asm_pos = asm_pos + 2'd1;
    end else begin
      mask = (n == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
      if (asm_pos == 2'd0) v = {24'h0, b};
      else if (fmt_cfg.little_endian) v = {8'h0, asm_part} | ({24'h0, b} << (8 * (n - 1)));
      else v = {asm_part, b};
      v = v & mask;
      word = v << (8 * (4 - n));
      if (n == 1 && fmt_cfg.little_endian) word = word ^ {FLIP_TOP, 24'h0};
      asm_part = '0;
      asm_pos  = 2'd0;
      fr.valid = 1'b1;
      if (fmt_cfg.channel_count <= 2'd1) begin
        asm_right = 1'b0;
        fr.left   = word;
        fr.right  = word;
        frames_q.push_back(fr);
      end else if (!asm_right) begin
        asm_held  = word;
        asm_right = 1'b1;
      end else begin
        asm_right = 1'b0;
        fr.left   = asm_held;
        fr.right  = word;
        frames_q.push_back(fr);
      end
    end
  endtask

  // Called at a rising edge; returns at the edge that accepts the item, valid still high
  task automatic send_byte(input logic [7:0] b, input logic sos);
    int gap;
    gap = tx_idle_en ? $urandom_range(19, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_byte            <= b;
    in_start_of_stream <= sos;
    do @(posedge clk); while (!in_ready);
    assemble_byte(b, sos);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (frames_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SAMPLE_BYTES:  fmt_cfg.sample_bytes  = d;
      REG_CHANNEL_COUNT: fmt_cfg.channel_count = d[1:0];
      REG_LITTLE_ENDIAN: fmt_cfg.little_endian = d[0];
      default: ;
    endcase
  endtask

  // Drain, let in-flight bytes settle, then load a new format
  task automatic set_format(input logic [2:0] nb, input logic [1:0] ch, input logic le,
                            input bit junk);
    wait_drained();
    repeat (4) @(posedge clk);
    if (junk) cfg_write(REG_NONE, 3'($urandom_range(7, 0)));
    cfg_write(REG_SAMPLE_BYTES, nb);
    cfg_write(REG_CHANNEL_COUNT, {1'($urandom_range(1, 0)), ch});
    cfg_write(REG_LITTLE_ENDIAN, {2'($urandom_range(3, 0)), le});
    cfg_valid <= 1'b0;
    formats_used++;
  endtask

  task automatic test_byte_extremes();
    // reset format: 16-bit little-endian stereo
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);  // realign in the middle of a sample
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  task automatic test_formats();
    set_format(3'd1, 2'd1, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    set_format(3'd1, 2'd2, 1'b0, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);
    set_format(3'd3, 2'd1, 1'b0, 1'b0);
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
  endtask

  task automatic test_cfg_corners();
    set_format(3'd0, 2'd0, 1'b1, 1'b1);
    send_byte(8'h5A, 1'b0);
    set_format(3'd7, 2'd3, 1'b1, 1'b0);
    send_byte(8'hA1, 1'b1);
    send_byte(8'hB2, 1'b0);
    send_byte(8'hC3, 1'b0);
    // shrink the sample while three bytes are held: next byte completes it
    set_format(3'd2, 2'd3, 1'b1, 1'b0);
    send_byte(8'hD4, 1'b0);
    // switch to mono while a right sample is pending
    set_format(3'd1, 2'd1, 1'b0, 1'b0);
    send_byte(8'hE5, 1'b0);
  endtask

  task automatic test_random_stream(input int unsigned n_items);
    int unsigned goal;
    int unsigned phase_end;
    int unsigned len;
    int unsigned i;
    logic [2:0]  nb;
    logic [1:0]  ch;
    goal = bytes_sent + n_items;
    while (bytes_sent < goal) begin
      if ($urandom_range(6, 0) == 0) begin
        nb = ($urandom_range(1, 0) == 0) ? 3'd0 : 3'($urandom_range(7, 5));
      end else begin
        nb = 3'($urandom_range(4, 1));
      end
      ch = ($urandom_range(4, 0) == 0) ? 2'($urandom_range(1, 0) * 3) : 2'($urandom_range(2, 1));
      set_format(nb, ch, 1'($urandom_range(1, 0)), $urandom_range(4, 0) == 0);
      tx_idle_en = $urandom_range(2, 0) != 0;
      rx_idle_en = $urandom_range(2, 0) != 0;
      phase_end = bytes_sent + $urandom_range(120, 20);
      while (bytes_sent < phase_end && bytes_sent < goal) begin
        if ($urandom_range(9, 0) != 0) begin
          len = sample_len() * ((fmt_cfg.channel_count >= 2'd2) ? 2 : 1);
          for (i = 0; i < len; i++) begin
            send_byte(rand_byte(), (i == 0) && ($urandom_range(1, 0) == 1));
          end
        end else begin
          len = $urandom_range(5, 1);
          for (i = 0; i < len; i++) begin
            send_byte(rand_byte(), $urandom_range(3, 0) == 0);
          end
        end
        if ($urandom_range(39, 0) == 0) wait_drained();
      end
    end
  endtask

  task automatic test_backpressure();
    set_format(3'd1, 2'd1, 1'($urandom_range(1, 0)), 1'b0);
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b1;
    rx_hold_cycles = 300;
    repeat (150) send_byte(rand_byte(), 1'b0);
  endtask

  task automatic test_drain_pause();
    int unsigned i;
    set_format(3'd3, 2'd2, 1'b0, 1'b0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (i = 0; i < 40; i++) send_byte(rand_byte(), i == 0);
    wait_drained();
    for (i = 0; i < 40; i++) send_byte(rand_byte(), 1'b0);
  endtask

  // Receiver: one random hold-off per frame, plus a long hold when a test asks
  initial begin : rx_side
    int gap;
    gap = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_valid && out_ready) gap = rx_idle_en ? $urandom_range(19, 0) : 0;
        if (rx_hold_cycles > 0) begin
          rx_hold_cycles--;
          out_ready <= 1'b0;
        end else if (gap > 0) begin
          gap--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frames_q.size() == 0) begin
        report_mismatch("frame with none expected, left", out_left_sample, '0);
      end else begin
        want = frames_q.pop_front();
        if (out_left_sample !== want.left)
          report_mismatch("left_sample", out_left_sample, want.left);
        if (out_right_sample !== want.right)
          report_mismatch("right_sample", out_right_sample, want.right);
        frames_checked++;
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_byte            <= '0;
    in_start_of_stream <= 1'b0;
    cfg_valid          <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    fmt_cfg        = '{RST_SAMPLE_BYTES, RST_CHANNEL_COUNT, RST_LITTLE_ENDIAN};
    asm_part       = '0;
    asm_pos        = 2'd0;
    asm_held       = '0;
    asm_right      = 1'b0;
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b0;
    rx_hold_cycles = 0;
    err_count      = 0;
    bytes_sent     = 0;
    frames_checked = 0;
    formats_used   = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_byte_extremes();
    test_formats();
    test_cfg_corners();
    test_random_stream(1250);
    test_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (8) @(posedge clk);
    $display("summary: %0d bytes in %0d formats, %0d frames checked, %0d mismatches",
             bytes_sent, formats_used, frames_checked, err_count);
    $display("summary: all sample sizes, mono and stereo, both byte orders, realign and stalls");
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
